>>> src/ukmp_pkg.sv
// ----------------------------------------------------------------------------
// ukmp_pkg
// types and constants for the usb key report to half-row matrix port
// ----------------------------------------------------------------------------
package ukmp_pkg;

  localparam int unsigned MaxHeldKeys = 6;
  localparam int unsigned NumRows     = 8;
  localparam int unsigned RowKeys     = 5;

  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_BUS    = 1'b1;

  localparam logic [7:0] HID_BACKSPACE  = 8'h2A;
  localparam logic [7:0] MOD_CTRL_MASK  = 8'h11;
  localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;
  localparam logic [7:0] ROW_IDLE       = 8'hFF;

  localparam logic [2:0] ROW_CAPS  = 3'd0;
  localparam logic [2:0] ROW_ZERO  = 3'd4;
  localparam logic [2:0] ROW_SPACE = 3'd7;

  localparam int unsigned BIT_CAPS_SHIFT = 0;
  localparam int unsigned BIT_ZERO_KEY   = 0;
  localparam int unsigned BIT_SYM_SHIFT  = 1;

  localparam logic [15:0] ROW_PORT [NumRows] = '{
    16'hFEFE, 16'hFDFE, 16'hFBFE, 16'hF7FE,
    16'hEFFE, 16'hDFFE, 16'hBFFE, 16'h7FFE
  };

  // hid usage per row, bit 0 first, zero for modifier-only positions
  localparam logic [7:0] ROW_CODES [NumRows][RowKeys] = '{
    '{8'h00, 8'h1D, 8'h1B, 8'h06, 8'h19},
    '{8'h04, 8'h16, 8'h07, 8'h09, 8'h0A},
    '{8'h14, 8'h1A, 8'h08, 8'h15, 8'h17},
    '{8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22},
    '{8'h27, 8'h26, 8'h25, 8'h24, 8'h23},
    '{8'h13, 8'h12, 8'h0C, 8'h18, 8'h1C},
    '{8'h28, 8'h0F, 8'h0E, 8'h0D, 8'h0B},
    '{8'h2C, 8'h00, 8'h10, 8'h11, 8'h05}
  };

  typedef struct packed {
    logic        opcode;
    logic [7:0]  modifiers;
    logic [7:0]  key_0;
    logic [7:0]  key_1;
    logic [7:0]  key_2;
    logic [7:0]  key_3;
    logic [7:0]  key_4;
    logic [7:0]  key_5;
    logic [15:0] bus_address;
    logic        bus_read;
    logic        bus_iorq;
  } in_item_t;

  typedef struct packed {
    logic       decoded;
    logic [7:0] read_data;
  } out_item_t;

endpackage

>>> src/ukmp_if.sv
// ----------------------------------------------------------------------------
// ukmp channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface ukmp_in_if;
  logic               valid;
  logic               ready;
  ukmp_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ukmp_out_if;
  logic                valid;
  logic                ready;
  ukmp_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/ukmp_keystore.sv
// ----------------------------------------------------------------------------
// ukmp_keystore
// holds the latest key report: held key codes and the modifier byte
// ----------------------------------------------------------------------------
module ukmp_keystore #(
  parameter int unsigned NUM_HELD_KEYS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  ukmp_pkg::in_item_t report_i,
  output logic [7:0]         keys_o [NUM_HELD_KEYS],
  output logic [7:0]         modifiers_o
);

  logic [7:0] report_keys [ukmp_pkg::MaxHeldKeys];
  logic [7:0] keys_q [NUM_HELD_KEYS];
  logic [7:0] mods_q;

  assign report_keys[0] = report_i.key_0;
  assign report_keys[1] = report_i.key_1;
  assign report_keys[2] = report_i.key_2;
  assign report_keys[3] = report_i.key_3;
  assign report_keys[4] = report_i.key_4;
  assign report_keys[5] = report_i.key_5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q <= '0;
      for (int i = 0; i < NUM_HELD_KEYS; i++) begin
        keys_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      mods_q <= report_i.modifiers;
      for (int i = 0; i < NUM_HELD_KEYS; i++) begin
        keys_q[i] <= report_keys[i];
      end
    end
  end

  assign keys_o      = keys_q;
  assign modifiers_o = mods_q;

endmodule

>>> src/ukmp_row_lookup.sv
// ----------------------------------------------------------------------------
// ukmp_row_lookup
// decodes a half-row port read and builds the active-low row byte
// ----------------------------------------------------------------------------
module ukmp_row_lookup #(
  parameter int unsigned NUM_HELD_KEYS = 6
) (
  input  logic [15:0]         bus_address_i,
  input  logic                bus_read_i,
  input  logic                bus_iorq_i,
  input  logic [7:0]          keys_i [NUM_HELD_KEYS],
  input  logic [7:0]          modifiers_i,
  output ukmp_pkg::out_item_t result_o
);

  logic       port_hit;
  logic [2:0] row_idx;
  logic [7:0] code;
  logic       key_match;
  logic       bs_held;
  logic [7:0] row_byte;

  always_comb begin
    port_hit = 1'b0;
    row_idx  = '0;
    for (int r = 0; r < ukmp_pkg::NumRows; r++) begin
      if (bus_address_i == ukmp_pkg::ROW_PORT[r]) begin
        port_hit = 1'b1;
        row_idx  = 3'(r);
      end
    end
  end

  always_comb begin
    bs_held = 1'b0;
    for (int i = 0; i < NUM_HELD_KEYS; i++) begin
      if (keys_i[i] == ukmp_pkg::HID_BACKSPACE) begin
        bs_held = 1'b1;
      end
    end
  end

  always_comb begin
    row_byte  = ukmp_pkg::ROW_IDLE;
    code      = '0;
    key_match = 1'b0;
    for (int j = 0; j < ukmp_pkg::RowKeys; j++) begin
      code      = ukmp_pkg::ROW_CODES[row_idx][j];
      key_match = 1'b0;
      for (int i = 0; i < NUM_HELD_KEYS; i++) begin
        if (keys_i[i] == code) begin
          key_match = 1'b1;
        end
      end
      if (key_match && (code != 8'h00)) begin
        row_byte[j] = 1'b0;
      end
    end
    // modifier-driven positions
    if ((row_idx == ukmp_pkg::ROW_CAPS) &&
        (bs_held || ((modifiers_i & ukmp_pkg::MOD_SHIFT_MASK) != 8'h00))) begin
      row_byte[ukmp_pkg::BIT_CAPS_SHIFT] = 1'b0;
    end
    if ((row_idx == ukmp_pkg::ROW_ZERO) && bs_held) begin
      row_byte[ukmp_pkg::BIT_ZERO_KEY] = 1'b0;
    end
    if ((row_idx == ukmp_pkg::ROW_SPACE) &&
        ((modifiers_i & ukmp_pkg::MOD_CTRL_MASK) != 8'h00)) begin
      row_byte[ukmp_pkg::BIT_SYM_SHIFT] = 1'b0;
    end
  end

  always_comb begin
    result_o.decoded   = bus_read_i & bus_iorq_i & port_hit;
    result_o.read_data = result_o.decoded ? row_byte : 8'h00;
  end

endmodule

>>> src/usb_keys_to_matrix_port_core.sv
// ----------------------------------------------------------------------------
// usb_keys_to_matrix_port_core
// keeps the latest usb key report and answers half-row keyboard port reads
//
//   channel  dir  transfer
//   in_i     in   key report (opcode 0) or bus access (opcode 1)
//   out_o    out  decoded flag and active-low row byte, one per bus access
//
// one item per cycle sustained while the result is not stalled; a bus access
// answers after passing the input register, then the result register
// a report updates the held keys as it leaves the input register, so later
// bus accesses see it; reset clears the report to no key held
// a stalled result holds the result register and backs up into the input
// register; reports still drain while a result waits
// ----------------------------------------------------------------------------
module usb_keys_to_matrix_port_core #(
  parameter int unsigned NUM_HELD_KEYS = 6
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ukmp_in_if.sink    in_i,
  ukmp_out_if.source out_o
);

  logic                in_valid_q;
  ukmp_pkg::in_item_t  in_item_q;
  logic                out_valid_q;
  ukmp_pkg::out_item_t out_item_q;

  logic                out_free;
  logic                is_bus;
  logic                s1_advance;
  logic                report_wr;
  logic [7:0]          held_keys [NUM_HELD_KEYS];
  logic [7:0]          held_mods;
  ukmp_pkg::out_item_t lookup_result;

  assign out_free   = !out_valid_q || out_o.ready;
  assign is_bus     = (in_item_q.opcode == ukmp_pkg::OP_BUS);
  assign s1_advance = in_valid_q && (!is_bus || out_free);
  assign report_wr  = in_valid_q && !is_bus;
  assign in_i.ready = !in_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= in_i.payload;
    end
  end

  ukmp_keystore #(
    .NUM_HELD_KEYS (NUM_HELD_KEYS)
  ) u_keystore (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (report_wr),
    .report_i    (in_item_q),
    .keys_o      (held_keys),
    .modifiers_o (held_mods)
  );

  ukmp_row_lookup #(
    .NUM_HELD_KEYS (NUM_HELD_KEYS)
  ) u_row_lookup (
    .bus_address_i (in_item_q.bus_address),
    .bus_read_i    (in_item_q.bus_read),
    .bus_iorq_i    (in_item_q.bus_iorq),
    .keys_i        (held_keys),
    .modifiers_i   (held_mods),
    .result_o      (lookup_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_advance && is_bus;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_advance && is_bus) begin
      out_item_q <= lookup_result;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

endmodule
